// ===== rtl/core/blake2b_keyed_hash_unit_macros.svh =====
// ----------------------------------------------------------------------------
// BLAKE2b hash unit assertion macros
// Shared assertion shorthands for the hash unit checkers.
// ----------------------------------------------------------------------------
`ifndef BLAKE2B_KEYED_HASH_UNIT_MACROS_SVH
`define BLAKE2B_KEYED_HASH_UNIT_MACROS_SVH

// implication checked on every clock edge outside reset
`define B2B_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication checked outside reset
`define B2B_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/b2b_pkg.sv =====
// ----------------------------------------------------------------------------
// BLAKE2b package
// Constants, tables and the mixing helpers shared by the hash unit.
// ----------------------------------------------------------------------------
package b2b_pkg;

   localparam int unsigned BLOCK_WORDS   = 16;
   localparam int unsigned ROUNDS        = 12;
   localparam int unsigned MAX_KEY_BYTES = 64;

   // configuration register indexes
   localparam logic [1:0] CSR_DIGEST_LENGTH = 2'd0;
   localparam logic [1:0] CSR_KEY_LENGTH    = 2'd1;

   typedef logic [63:0] word_type;

   // word handed from the ingest side to the compression side
   typedef struct packed {
      logic [63:0] data;
      logic [3:0]  nbytes;  // bytes added, 0..8
      logic        eom;
   } ing_word_type;

   localparam logic [63:0] IV [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
      64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
      64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   localparam logic [31:0] PARAM_BASE = 32'h01010000;

   localparam logic [3:0] SIGMA [10][16] = '{
      '{ 0, 1, 2, 3, 4, 5, 6, 7, 8, 9,10,11,12,13,14,15},
      '{14,10, 4, 8, 9,15,13, 6, 1,12, 0, 2,11, 7, 5, 3},
      '{11, 8,12, 0, 5, 2,15,13,10,14, 3, 6, 7, 1, 9, 4},
      '{ 7, 9, 3, 1,13,12,11,14, 2, 6, 5,10, 4, 0,15, 8},
      '{ 9, 0, 5, 7, 2, 4,10,15,14, 1,11,12, 6, 8, 3,13},
      '{ 2,12, 6,10, 0,11, 8, 3, 4,13, 7, 5,15,14, 1, 9},
      '{12, 5, 1,15,14,13, 4,10, 0, 7, 6, 3, 9, 2, 8,11},
      '{13,11, 7,14,12, 1, 3, 9, 5, 0,15, 4, 8, 6, 2,10},
      '{ 6,15,14, 9,11, 3, 0, 8,12, 2,13, 7, 1, 4,10, 5},
      '{10, 2, 8, 4, 7, 6, 1, 5,15,11, 9,14, 3,12,13, 0}
   };

   // mixing function input/outputs: columns then diagonals
   localparam logic [3:0] GA [8] = '{0,1,2,3,0,1,2,3};
   localparam logic [3:0] GB [8] = '{4,5,6,7,5,6,7,4};
   localparam logic [3:0] GC [8] = '{8,9,10,11,10,11,8,9};
   localparam logic [3:0] GD [8] = '{12,13,14,15,15,12,13,14};

   function automatic logic [63:0] ror64(input logic [63:0] x, input int unsigned n);
      ror64 = (x >> n) | (x << (64 - n));
   endfunction

   function automatic logic [63:0] byte_mask(input logic [3:0] nb);
      logic [63:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < nb) begin
            m[8*i +: 8] = 8'hff;
         end
      end
      byte_mask = m;
   endfunction

endpackage

// ===== rtl/core/b2b_ingest.sv =====
// ----------------------------------------------------------------------------
// BLAKE2b ingest
// Accepts request words, normalizes the byte count and masks short words.
// ----------------------------------------------------------------------------
module b2b_ingest
   import b2b_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  logic [63:0]  req_data_word,
   input  logic [3:0]   req_byte_count,
   input  logic         req_end_of_message,
   output logic         q_push,
   output ing_word_type q_word,
   input  logic         q_full
);

   logic         stage_valid_ff, stage_valid_in;
   ing_word_type stage_ff;
   logic [3:0]   cnt;

   assign req_full = stage_valid_ff && q_full;
   assign q_push   = stage_valid_ff;
   assign q_word   = stage_ff;

   always_comb begin
      cnt = (!req_end_of_message || req_byte_count > 4'd8) ? 4'd8 : req_byte_count;
      stage_valid_in = stage_valid_ff;
      if (stage_valid_ff && !q_full) begin
         stage_valid_in = 1'b0;
      end
      if (req_push && !req_full) begin
         stage_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      if (req_push && !req_full) begin
         stage_ff.data   <= req_data_word & byte_mask(cnt);
         stage_ff.nbytes <= cnt;
         stage_ff.eom    <= req_end_of_message;
      end
   end

endmodule

// ===== rtl/core/b2b_fifo.sv =====
// ----------------------------------------------------------------------------
// BLAKE2b word queue
// Short register queue between ingest and compression.
// ----------------------------------------------------------------------------
module b2b_fifo
   import b2b_pkg::*;
#(
   parameter int unsigned DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  ing_word_type wdata,
   output logic         full,
   input  logic         pop,
   output ing_word_type rdata,
   output logic         empty
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   ing_word_type      mem_ff [DEPTH];
   logic [AW-1:0]     wp_ff, rp_ff;
   logic [AW:0]       cnt_ff;

   assign full  = (cnt_ff == (AW+1)'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign rdata = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push && !full) begin
            wp_ff <= (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
         end
         if (pop && !empty) begin
            rp_ff <= (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
      end
      if (push && !full) begin
         mem_ff[wp_ff] <= wdata;
      end
   end

endmodule

// ===== rtl/core/b2b_core.sv =====
// ----------------------------------------------------------------------------
// BLAKE2b compression engine
// Buffers a block, runs the rounds one mixing step a cycle, emits the digest.
// ----------------------------------------------------------------------------
module b2b_core
   import b2b_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write,
   input  logic [1:0]   csr_index,
   input  logic [6:0]   csr_data,
   input  logic         q_empty,
   input  ing_word_type q_word,
   output logic         q_pop,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output logic [63:0]  rsp_digest_word,
   output logic [2:0]   rsp_word_index,
   output logic [3:0]   rsp_digest_bytes,
   output logic         rsp_last_word
);

   typedef enum logic [2:0] {
      ST_TAKE, ST_INIT, ST_MIX, ST_FOLD, ST_OUT
   } state_type;

   state_type   state_ff;
   logic [6:0]  dlen_ff, klen_ff;
   logic [63:0] h_ff [8];
   logic [63:0] v_ff [16];
   logic [63:0] m_ff [16];
   logic [7:0]  fill_ff;
   logic [127:0] cnt_ff;
   logic        final_ff;
   logic [3:0]  round_ff;
   logic [2:0]  gstep_ff;
   logic [3:0]  sig_row;
   logic [2:0]  oidx_ff;
   logic        out_valid_ff;
   logic [6:0]  dl_eff;
   logic [6:0]  kl_eff;
   logic [63:0] pword;
   logic [3:0]  ia, ib, ic, id;
   logic [63:0] a1, d1, c1, b1, a2, d2, c2, b2, mx, my;
   logic [3:0]  nwords;
   logic [6:0]  rem;
   logic [127:0] cnt_add;
   logic        idle;

   always_comb begin
      dl_eff = (dlen_ff == '0) ? 7'd1 : (dlen_ff > 7'd64 ? 7'd64 : dlen_ff);
      kl_eff = (klen_ff > 7'(MAX_KEY_BYTES)) ? 7'(MAX_KEY_BYTES) : klen_ff;
      pword  = {32'h0, PARAM_BASE} ^ {49'h0, kl_eff, 8'h0} ^ {57'h0, dl_eff};
      nwords = 4'((dl_eff + 7'd7) >> 3);
      rem    = dl_eff - {1'b0, oidx_ff, 3'b000};
      sig_row = (round_ff >= 4'd10) ? round_ff - 4'd10 : round_ff;
      ia = GA[gstep_ff]; ib = GB[gstep_ff]; ic = GC[gstep_ff]; id = GD[gstep_ff];
      mx = m_ff[SIGMA[sig_row][{gstep_ff, 1'b0}]];
      my = m_ff[SIGMA[sig_row][{gstep_ff, 1'b1}]];
      a1 = v_ff[ia] + v_ff[ib] + mx;
      d1 = ror64(v_ff[id] ^ a1, 32);
      c1 = v_ff[ic] + d1;
      b1 = ror64(v_ff[ib] ^ c1, 24);
      a2 = a1 + b1 + my;
      d2 = ror64(d1 ^ a2, 16);
      c2 = c1 + d2;
      b2 = ror64(b1 ^ c2, 63);
      idle = (fill_ff == '0) && (cnt_ff == '0);
      cnt_add = '0;
      q_pop = 1'b0;
      if (state_ff == ST_TAKE && !q_empty) begin
         if (q_word.nbytes != '0 && fill_ff >= 8'd128) begin
            cnt_add = 128'd128;
         end else begin
            q_pop = 1'b1;
            if (q_word.eom) begin
               cnt_add = {120'h0, fill_ff + 8'(q_word.nbytes)};
            end
         end
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_word_index = oidx_ff;
   assign rsp_digest_bytes = (rem > 7'd8) ? 4'd8 : rem[3:0];
   assign rsp_last_word = (4'(oidx_ff) + 4'd1 == nwords);
   assign rsp_digest_word = h_ff[oidx_ff] & byte_mask(rsp_digest_bytes);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_TAKE;
         dlen_ff      <= 7'd64;
         klen_ff      <= 7'd0;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= (i == 0) ? IV[0] ^ 64'h01010040 : IV[i];
         end
      end else begin
         if (csr_write && csr_index == CSR_DIGEST_LENGTH) begin
            dlen_ff <= csr_data;
         end
         if (csr_write && csr_index == CSR_KEY_LENGTH) begin
            klen_ff <= csr_data;
         end
         unique case (state_ff)
            ST_TAKE: begin
               if (idle && state_ff == ST_TAKE) begin
                  // keep chain loaded with current parameter word
                  h_ff[0] <= IV[0] ^ pword;
                  for (int i = 1; i < 8; i++) begin
                     h_ff[i] <= IV[i];
                  end
               end
               if (!q_empty) begin
                  cnt_ff <= cnt_ff + cnt_add;
                  if (q_word.nbytes != '0 && fill_ff >= 8'd128) begin
                     final_ff <= 1'b0;
                     fill_ff  <= '0;
                     state_ff <= ST_INIT;
                  end else begin
                     if (q_word.nbytes != '0) begin
                        m_ff[fill_ff[6:3]] <= q_word.data;
                     end
                     if (q_word.eom) begin
                        for (int i = 0; i < BLOCK_WORDS; i++) begin
                           if (5'(i) >= 5'((fill_ff + 8'(q_word.nbytes) + 8'd7) >> 3)) begin
                              m_ff[i] <= '0;
                           end
                        end
                        final_ff <= 1'b1;
                        state_ff <= ST_INIT;
                     end else begin
                        fill_ff <= fill_ff + 8'(q_word.nbytes);
                     end
                  end
               end
            end
            ST_INIT: begin
               for (int i = 0; i < 8; i++) begin
                  v_ff[i]   <= h_ff[i];
                  v_ff[i+8] <= IV[i];
               end
               v_ff[12] <= IV[4] ^ cnt_ff[63:0];
               v_ff[13] <= IV[5] ^ cnt_ff[127:64];
               v_ff[14] <= final_ff ? ~IV[6] : IV[6];
               round_ff <= '0;
               gstep_ff <= '0;
               state_ff <= ST_MIX;
            end
            ST_MIX: begin
               v_ff[ia] <= a2; v_ff[ib] <= b2; v_ff[ic] <= c2; v_ff[id] <= d2;
               gstep_ff <= gstep_ff + 3'd1;
               if (gstep_ff == 3'd7) begin
                  round_ff <= round_ff + 4'd1;
                  if (round_ff == 4'(ROUNDS - 1)) begin
                     state_ff <= ST_FOLD;
                  end
               end
            end
            ST_FOLD: begin
               for (int i = 0; i < 8; i++) begin
                  h_ff[i] <= h_ff[i] ^ v_ff[i] ^ v_ff[i+8];
               end
               if (final_ff) begin
                  oidx_ff      <= '0;
                  out_valid_ff <= 1'b1;
                  state_ff     <= ST_OUT;
               end else begin
                  state_ff <= ST_TAKE;
               end
            end
            ST_OUT: begin
               if (rsp_pop) begin
                  oidx_ff <= oidx_ff + 3'd1;
                  if (rsp_last_word) begin
                     out_valid_ff <= 1'b0;
                     fill_ff      <= '0;
                     cnt_ff       <= '0;
                     state_ff     <= ST_TAKE;
                  end
               end
            end
            default: state_ff <= ST_TAKE;
         endcase
      end
   end

endmodule

// ===== rtl/core/blake2b_keyed_hash_unit.sv =====
// BLAKE2b hash unit: message words enter through a queue port at one per cycle
// while full is low, into a small ingest queue; the compression engine takes
// one word per cycle into its block buffer while the queue holds words and
// runs one mixing step per cycle, so each 128-byte block is taken word by word
// and then compressed (start, load, 96 mixing steps, fold); no new word is
// taken while a block compresses. After the final word the digest leaves as
// 1 to 8 words.
// ----------------------------------------------------------------------------
// BLAKE2b hash unit top level
// Ingest front end, word queue and compression back end.
// ----------------------------------------------------------------------------
module blake2b_keyed_hash_unit
   import b2b_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_data,
   input  logic        req_push,
   output logic        full,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_byte_count,
   input  logic        req_end_of_message,
   output logic        empty,
   input  logic        pop,
   output logic [63:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic [3:0]  rsp_digest_bytes,
   output logic        rsp_last_word
);

   logic         q_push, q_full, q_pop, q_empty;
   ing_word_type q_wdata, q_rdata;

   b2b_ingest u_ingest (
      .clock, .reset,
      .req_push, .req_full(full), .req_data_word, .req_byte_count,
      .req_end_of_message,
      .q_push, .q_word(q_wdata), .q_full
   );

   b2b_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock, .reset,
      .push(q_push), .wdata(q_wdata), .full(q_full),
      .pop(q_pop), .rdata(q_rdata), .empty(q_empty)
   );

   b2b_core u_core (
      .clock, .reset,
      .csr_write, .csr_index, .csr_data,
      .q_empty, .q_word(q_rdata), .q_pop,
      .rsp_empty(empty), .rsp_pop(pop),
      .rsp_digest_word, .rsp_word_index, .rsp_digest_bytes, .rsp_last_word
   );

endmodule

// ===== rtl/core/b2b_checker.sv =====
// ----------------------------------------------------------------------------
// BLAKE2b hash unit checker
// Port-level checks on the digest stream.
// ----------------------------------------------------------------------------
`include "blake2b_keyed_hash_unit_macros.svh"
module b2b_checker (
   input logic       clock,
   input logic       reset,
   input logic       empty,
   input logic       pop,
   input logic [2:0] rsp_word_index,
   input logic [3:0] rsp_digest_bytes,
   input logic       rsp_last_word
);

   `B2B_ASSERT_IMPL(a_bytes_range, clock, reset, !empty, rsp_digest_bytes != 4'd0 && rsp_digest_bytes <= 4'd8, "digest bytes out of range")
   `B2B_ASSERT_IMPL(a_short_is_last, clock, reset, !empty && rsp_digest_bytes != 4'd8, rsp_last_word, "short word not last")
   `B2B_ASSERT_NEXT(a_index_step, clock, reset, !empty && pop && !rsp_last_word, !empty && rsp_word_index == $past(rsp_word_index) + 3'd1, "digest index skipped")
   `B2B_ASSERT_NEXT(a_hold, clock, reset, !empty && !pop, !empty && $stable(rsp_word_index), "digest word dropped")

endmodule

bind blake2b_keyed_hash_unit b2b_checker u_b2b_checker (
   .clock, .reset, .empty, .pop, .rsp_word_index, .rsp_digest_bytes, .rsp_last_word
);

// ===== test/blake2b_keyed_hash_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BLAKE2b hash unit testbench
// Streams keyed and unkeyed messages through the queue ports under random
// gaps and stalls and compares every digest word with a built-in model.
// ----------------------------------------------------------------------------
module blake2b_keyed_hash_unit_tb;
   import b2b_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned DRAIN_CYCLES = 250;
   localparam int unsigned PHASE_ITEMS  = 35;
   localparam logic [1:0] REG_DIGEST_LEN = CSR_DIGEST_LENGTH;
   localparam logic [1:0] REG_KEY_LEN    = CSR_KEY_LENGTH;
   localparam logic [1:0] REG_UNUSED     = 2'd3;

   typedef struct {
      logic [63:0] word;
      logic [2:0]  index;
      logic [3:0]  nbytes;
      logic        last;
   } digest_word_type;

   typedef struct {
      logic [63:0] data;
      logic [3:0]  count;
      logic        eom;
      bit          known;
      logic [63:0] first_word;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [6:0]  csr_data = '0;
   logic        req_push = 1'b0;
   logic        full;
   logic [63:0] req_data_word = '0;
   logic [3:0]  req_byte_count = '0;
   logic        req_end_of_message = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic [63:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic [3:0]  rsp_digest_bytes;
   logic        rsp_last_word;

   // hash state mirrored by the testbench
   logic [6:0]   digest_len_reg;
   logic [6:0]   key_len_reg;
   logic [63:0]  chain[8];
   logic [127:0] bytes_hashed;
   logic [63:0]  block[16];
   int unsigned  fill;

   digest_word_type digest_q[$];
   int unsigned  fails = 0;
   int unsigned  words_sent = 0;
   int unsigned  digests_seen = 0;
   int unsigned  messages = 0;
   int unsigned  cycles = 0;
   bit           no_idle = 1'b0;
   bit           known_pending = 1'b0;
   logic [63:0]  known_word;

   blake2b_keyed_hash_unit dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d digest words outstanding",
                  cycles, digest_q.size());
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
      return (x >> n) | (x << (64 - n));
   endfunction

   function automatic void load_chain();
      int unsigned dl, kl;
      dl = (digest_len_reg == 0) ? 1 : (digest_len_reg > 64) ? 64 : digest_len_reg;
      kl = (key_len_reg > 64) ? 64 : key_len_reg;
      for (int i = 0; i < 8; i++) chain[i] = IV[i];
      chain[0] ^= 64'(PARAM_BASE) ^ (64'(kl) << 8) ^ 64'(dl);
   endfunction

   function automatic void compress(input bit final_blk);
      logic [63:0] v[16];
      logic [63:0] x, y;
      int unsigned a, b, c, d;
      for (int i = 0; i < 8; i++) begin
         v[i] = chain[i];
         v[i+8] = IV[i];
      end
      v[12] ^= bytes_hashed[63:0];
      v[13] ^= bytes_hashed[127:64];
      if (final_blk) v[14] = ~v[14];
      for (int r = 0; r < ROUNDS; r++) begin
         for (int j = 0; j < 8; j++) begin
            a = GA[j]; b = GB[j]; c = GC[j]; d = GD[j];
            x = block[SIGMA[r % 10][2*j]];
            y = block[SIGMA[r % 10][2*j+1]];
            v[a] = v[a] + v[b] + x;
            v[d] = rotr(v[d] ^ v[a], 32);
            v[c] = v[c] + v[d];
            v[b] = rotr(v[b] ^ v[c], 24);
            v[a] = v[a] + v[b] + y;
            v[d] = rotr(v[d] ^ v[a], 16);
            v[c] = v[c] + v[d];
            v[b] = rotr(v[b] ^ v[c], 63);
         end
      end
      for (int i = 0; i < 8; i++) chain[i] ^= v[i] ^ v[i+8];
   endfunction

   function automatic void absorb_word(input logic [63:0] data, input logic [3:0] count,
                                       input logic eom);
      int unsigned n, dl, nwords, nb;
      logic [63:0] w;
      digest_word_type e;
      n = (!eom || count > 8) ? 8 : count;
      if (n > 0) begin
         if (fill >= 128) begin
            bytes_hashed += 128;
            compress(1'b0);
            fill = 0;
         end
         if (n < 8) data &= (64'd1 << (8 * n)) - 1;
         block[(fill >> 3) & 15] = data;
         fill += n;
      end
      if (!eom) return;
      bytes_hashed += fill;
      for (int i = (fill + 7) >> 3; i < 16; i++) block[i] = '0;
      compress(1'b1);
      dl = (digest_len_reg == 0) ? 1 : (digest_len_reg > 64) ? 64 : digest_len_reg;
      nwords = (dl + 7) >> 3;
      for (int i = 0; i < nwords; i++) begin
         nb = dl - 8 * i;
         if (nb > 8) nb = 8;
         w = chain[i];
         if (nb < 8) w &= (64'd1 << (8 * nb)) - 1;
         e.word = w;
         e.index = 3'(i);
         e.nbytes = 4'(nb);
         e.last = (i + 1 == nwords);
         // a known-answer row pins the first word to the published value
         if (i == 0 && known_pending) e.word = known_word;
         digest_q.push_back(e);
      end
      known_pending = 1'b0;
      messages++;
      load_chain();
      bytes_hashed = '0;
      fill = 0;
   endfunction

   // accepted words, register writes and digest words, all sampled at the edge
   always @(posedge clock) begin
      digest_word_type e;
      if (!reset) begin
         if (csr_write) begin
            if (csr_index == REG_DIGEST_LEN) digest_len_reg = csr_data;
            if (csr_index == REG_KEY_LEN) key_len_reg = csr_data;
            if ((csr_index == REG_DIGEST_LEN || csr_index == REG_KEY_LEN) &&
                fill == 0 && bytes_hashed == 0) load_chain();
         end
         if (req_push && !full) begin
            words_sent++;
            absorb_word(req_data_word, req_byte_count, req_end_of_message);
         end
         if (pop && !empty) begin
            digests_seen++;
            if (digest_q.size() == 0) begin
               $display("%0t: unexpected digest word %h index %0d", $time,
                        rsp_digest_word, rsp_word_index);
               fails++;
            end else begin
               e = digest_q.pop_front();
               if (rsp_digest_word !== e.word) begin
                  $display("%0t: digest_word expected %h actual %h", $time,
                           e.word, rsp_digest_word);
                  fails++;
               end
               if (rsp_word_index !== e.index) begin
                  $display("%0t: word_index expected %0d actual %0d", $time,
                           e.index, rsp_word_index);
                  fails++;
               end
               if (rsp_digest_bytes !== e.nbytes) begin
                  $display("%0t: digest_bytes expected %0d actual %0d", $time,
                           e.nbytes, rsp_digest_bytes);
                  fails++;
               end
               if (rsp_last_word !== e.last) begin
                  $display("%0t: last_word expected %0d actual %0d", $time,
                           e.last, rsp_last_word);
                  fails++;
               end
            end
         end
      end
   end

   // digest side: hold pop low for a random stall, if any, before each word
   initial begin
      int unsigned stall;
      wait (!reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
      end
   end

   // hold the word until it is taken; push stays high into a back-to-back word
   task automatic send_word(input logic [63:0] data, input logic [3:0] count,
                            input logic eom);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data_word <= data;
      req_byte_count <= count;
      req_end_of_message <= eom;
      do @(posedge clock); while (full);
   endtask

   task automatic send_message(input int unsigned nwords);
      int unsigned keyed;
      keyed = (key_len_reg > 64) ? 64 : key_len_reg;
      // key block: key bytes in the low words, zero padding to 128 bytes
      if (keyed > 0) begin
         for (int i = 0; i < 16; i++)
            send_word((8 * i < keyed) ? {$urandom, $urandom} : 64'd0,
                      4'($urandom_range(0, 15)), 1'b0);
      end
      for (int i = 0; i < nwords; i++)
         send_word({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b0);
      send_word({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b1);
   endtask

   task automatic settle();
      req_push <= 1'b0;
      while (digest_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one write cycle, then the write is dropped before the task returns
   task automatic write_reg(input logic [1:0] idx, input logic [6:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   dir_row_type dir_rows[] = '{
      '{64'h0000000000636261, 4'd3,  1'b1, 1'b1, 64'h0d4d1c983fa580ba},
      '{64'h0,                4'd0,  1'b1, 1'b1, 64'h03590142f7026a78},
      '{64'hffffffffffffffff, 4'd15, 1'b0, 1'b0, 64'h0},
      '{64'h0,                4'd0,  1'b0, 1'b0, 64'h0},
      '{64'hffffffffffffffff, 4'd8,  1'b1, 1'b0, 64'h0},
      '{64'h0123456789abcdef, 4'd9,  1'b1, 1'b0, 64'h0},
      '{64'hffffffffffffffff, 4'd1,  1'b1, 1'b0, 64'h0},
      '{64'h8000000000000001, 4'd3,  1'b0, 1'b0, 64'h0},
      '{64'hfedcba9876543210, 4'd7,  1'b1, 1'b0, 64'h0},
      '{64'h5555aaaa5555aaaa, 4'd0,  1'b1, 1'b0, 64'h0}
   };

   logic [6:0] settings[8][2] = '{
      '{7'd32, 7'd0}, '{7'd1, 7'd64}, '{7'd0, 7'd1}, '{7'd127, 7'd127},
      '{7'd20, 7'd32}, '{7'd64, 7'd64}, '{7'd8, 7'd16}, '{7'd64, 7'd0}
   };

   initial begin
      int unsigned start, len;
      digest_len_reg = 7'd64;
      key_len_reg = 7'd0;
      load_chain();
      bytes_hashed = '0;
      fill = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // known answers and field extremes at the reset settings
      foreach (dir_rows[i]) begin
         known_pending = dir_rows[i].known;
         known_word = dir_rows[i].first_word;
         send_word(dir_rows[i].data, dir_rows[i].count, dir_rows[i].eom);
         if (dir_rows[i].known) settle();
      end
      // exactly one full block, ended by an empty marked word, then ended in-block
      for (int i = 0; i < 16; i++) send_word({$urandom, $urandom}, 4'd8, 1'b0);
      send_word(64'h0, 4'd0, 1'b1);
      for (int i = 0; i < 15; i++) send_word({$urandom, $urandom}, 4'd8, 1'b0);
      send_word({$urandom, $urandom}, 4'd8, 1'b1);
      settle();

      write_reg(REG_UNUSED, 7'h7f);
      foreach (settings[p]) begin
         settle();
         write_reg(REG_DIGEST_LEN, settings[p][0]);
         write_reg(REG_KEY_LEN, settings[p][1]);
         no_idle = (p % 3 == 2);
         start = words_sent;
         while (words_sent - start < PHASE_ITEMS) begin
            // mostly short messages, now and then several blocks
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48)
                                             : $urandom_range(0, 20);
            send_message(len);
         end
      end
      no_idle = 1'b0;
      settle();

      $display("hashed %0d messages from %0d words over 8 register settings",
               messages, words_sent);
      $display("checked %0d digest words, %0d mismatches", digests_seen, fails);
      if (fails == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== blake2b_keyed_hash_unit.f =====
+incdir+rtl/core
rtl/core/b2b_pkg.sv
rtl/core/b2b_ingest.sv
rtl/core/b2b_fifo.sv
rtl/core/b2b_core.sv
rtl/core/blake2b_keyed_hash_unit.sv
rtl/core/b2b_checker.sv
test/blake2b_keyed_hash_unit_tb.sv
